### rtl/core/aos_pkg.sv
//==============================================================================
// aos_pkg
// shared constants and types for the angular order sorter
//==============================================================================
`default_nettype none

package aos_pkg;

    localparam int MAX_POINTS = 32;
    localparam int COORD_BITS = 16;
    localparam int TAG_BITS   = 10;
    localparam int IDX_BITS   = $clog2(MAX_POINTS);
    localparam int CNT_BITS   = $clog2(MAX_POINTS + 1);
    localparam int PROD_BITS  = 2 * COORD_BITS;

    // configuration register indexes
    localparam logic [0:0] REG_REF_X = 1'b0;
    localparam logic [0:0] REG_REF_Y = 1'b1;

    // datapath commands
    typedef enum logic [2:0] {
        CMD_NONE,
        CMD_LOAD_A,
        CMD_LOAD_B,
        CMD_MUL_REF,
        CMD_MUL_PAIR
    } t_cmd;

    typedef struct packed {
        t_cmd                cmd;
        logic [IDX_BITS-1:0] addr_a;
        logic [IDX_BITS-1:0] addr_b;
    } t_dp_ctrl;

    typedef struct packed {
        logic first_grp;  // vector a lies in the first group
        logic precedes;   // cross(a, b) > 0
    } t_dp_stat;

endpackage

`default_nettype wire

### rtl/core/aos_datapath.sv
//==============================================================================
// aos_datapath
// vector store, reference registers and cross/dot product unit
//==============================================================================
`default_nettype none

module aos_datapath (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_wr_en,
    input  wire logic [aos_pkg::IDX_BITS-1:0]        i_wr_addr,
    input  wire logic [aos_pkg::TAG_BITS-1:0]        i_wr_tag,
    input  wire logic signed [aos_pkg::COORD_BITS-1:0] i_wr_x,
    input  wire logic signed [aos_pkg::COORD_BITS-1:0] i_wr_y,
    input  wire logic                                i_cfg_we,
    input  wire logic                                i_cfg_idx,
    input  wire logic signed [aos_pkg::COORD_BITS-1:0] i_cfg_data,
    input  wire aos_pkg::t_dp_ctrl                   i_ctrl,
    output aos_pkg::t_dp_stat                        o_stat,
    output logic [aos_pkg::TAG_BITS-1:0]             o_tag_a
);
    import aos_pkg::*;

    logic [TAG_BITS-1:0]          r_mem_tag [MAX_POINTS];
    logic signed [COORD_BITS-1:0] r_mem_x   [MAX_POINTS];
    logic signed [COORD_BITS-1:0] r_mem_y   [MAX_POINTS];

    logic signed [COORD_BITS-1:0] r_ref_x, r_ref_y;
    logic signed [COORD_BITS-1:0] r_ax, r_ay, r_bx, r_by;
    logic [TAG_BITS-1:0]          r_tag_a;
    logic signed [PROD_BITS-1:0]  r_p1, r_p2, r_p3, r_p4;
    logic signed [COORD_BITS-1:0] n_m1, n_m2, n_m3, n_m4;

    // vector store: one write port, one read port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem_tag[i_wr_addr] <= i_wr_tag;
            r_mem_x[i_wr_addr]   <= i_wr_x;
            r_mem_y[i_wr_addr]   <= i_wr_y;
        end
        if (i_ctrl.cmd == CMD_LOAD_A) begin
            r_ax    <= r_mem_x[i_ctrl.addr_a];
            r_ay    <= r_mem_y[i_ctrl.addr_a];
            r_tag_a <= r_mem_tag[i_ctrl.addr_a];
        end
        if (i_ctrl.cmd == CMD_LOAD_B) begin
            r_bx <= r_mem_x[i_ctrl.addr_b];
            r_by <= r_mem_y[i_ctrl.addr_b];
        end
    end

    // reference direction registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ref_x <= COORD_BITS'(1);
            r_ref_y <= '0;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == REG_REF_X) r_ref_x <= i_cfg_data;
            else                        r_ref_y <= i_cfg_data;
        end
    end

    // multiplier operand select
    always_comb begin
        if (i_ctrl.cmd == CMD_MUL_REF) begin
            n_m1 = r_ref_y; n_m2 = r_ref_x; n_m3 = r_ref_x; n_m4 = r_ref_y;
        end else begin
            n_m1 = r_by;    n_m2 = r_bx;    n_m3 = r_bx;    n_m4 = r_by;
        end
    end

    // products registered; p1-p2 is cross, p3+p4 is dot
    always_ff @(posedge i_clk) begin
        if (i_ctrl.cmd == CMD_MUL_REF || i_ctrl.cmd == CMD_MUL_PAIR) begin
            r_p1 <= r_ax * n_m1;
            r_p2 <= r_ay * n_m2;
            r_p3 <= r_ax * n_m3;
            r_p4 <= r_ay * n_m4;
        end
    end

    // compares on registered products
    always_comb begin
        o_stat.first_grp = (r_p1 < r_p2) ||
                           ((r_p1 == r_p2) && ((PROD_BITS+1)'(r_p3) + (PROD_BITS+1)'(r_p4)
                                               > $signed((PROD_BITS+1)'(0))));
        o_stat.precedes  = r_p1 > r_p2;
    end

    assign o_tag_a = r_tag_a;

endmodule

`default_nettype wire

### rtl/core/aos_ctrl.sv
//==============================================================================
// aos_ctrl
// sequencer: loads vectors, partitions, insertion sorts, streams tags
//==============================================================================
`default_nettype none

module aos_ctrl (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    input  wire logic                          i_in_last,
    output logic                               o_in_ready,
    output logic                               o_wr_en,
    output logic [aos_pkg::IDX_BITS-1:0]       o_wr_addr,
    output aos_pkg::t_dp_ctrl                  o_ctrl,
    input  wire aos_pkg::t_dp_stat             i_stat,
    input  wire logic [aos_pkg::TAG_BITS-1:0]  i_tag_a,
    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    output logic [aos_pkg::TAG_BITS-1:0]       o_out_tag,
    output logic                               o_out_last,
    output logic                               o_out_ovf
);
    import aos_pkg::*;

    typedef enum logic [3:0] {
        S_LOAD, S_PA, S_PM, S_PC, S_SA, S_SB, S_SM, S_SC,
        S_OA, S_OW, S_OUT
    } t_state;

    t_state              r_state;
    logic [CNT_BITS-1:0] r_cnt, r_i, r_k, r_split, r_fill, r_lo, r_hi;
    logic                r_ovf, r_grp2;
    logic [IDX_BITS-1:0] r_ord [MAX_POINTS];
    logic [IDX_BITS-1:0] r_key;
    logic                r_out_valid, r_out_last, r_out_ovf;
    logic [TAG_BITS-1:0] r_out_tag;

    logic in_fire;
    assign in_fire   = i_in_valid && o_in_ready;
    assign o_in_ready = (r_state == S_LOAD);
    assign o_wr_en   = in_fire && (r_cnt < CNT_BITS'(MAX_POINTS));
    assign o_wr_addr = r_cnt[IDX_BITS-1:0];

    // datapath commands from the current state
    always_comb begin
        o_ctrl.cmd    = CMD_NONE;
        o_ctrl.addr_a = r_i[IDX_BITS-1:0];
        o_ctrl.addr_b = r_ord[r_k[IDX_BITS-1:0] - IDX_BITS'(1)];
        case (r_state)
            S_PA:    o_ctrl.cmd = CMD_LOAD_A;
            S_PM:    o_ctrl.cmd = CMD_MUL_REF;
            S_SA: begin
                o_ctrl.cmd    = CMD_LOAD_A;
                o_ctrl.addr_a = r_ord[r_i[IDX_BITS-1:0]];
            end
            S_SB:    o_ctrl.cmd = CMD_LOAD_B;
            S_SM:    o_ctrl.cmd = CMD_MUL_PAIR;
            S_OA: begin
                o_ctrl.cmd    = CMD_LOAD_A;
                o_ctrl.addr_a = r_ord[r_i[IDX_BITS-1:0]];
            end
            default: o_ctrl.cmd = CMD_NONE;
        endcase
    end

    // state, order list and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_LOAD;
            r_cnt       <= '0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
            r_grp2      <= 1'b0;
        end else begin
            case (r_state)
                S_LOAD: begin
                    if (in_fire) begin
                        if (r_cnt < CNT_BITS'(MAX_POINTS)) r_cnt <= r_cnt + 1'b1;
                        else                                r_ovf <= 1'b1;
                        if (i_in_last) begin
                            r_i     <= '0;
                            r_split <= '0;
                            r_state <= S_PA;
                        end
                    end
                end
                // passes 1 and 2: first group into the front of the list, then the rest behind it
                S_PA: r_state <= S_PM;
                S_PM: r_state <= S_PC;
                S_PC: begin
                    if (i_stat.first_grp != r_grp2) begin
                        r_ord[r_split[IDX_BITS-1:0]] <= r_i[IDX_BITS-1:0];
                        r_split <= r_split + 1'b1;
                    end
                    if (r_i + 1'b1 == r_cnt) begin
                        if (!r_grp2) begin
                            r_i    <= '0;
                            r_grp2 <= 1'b1;
                            r_fill <= r_split + CNT_BITS'(i_stat.first_grp);
                            r_state <= S_PA;
                        end else begin
                            r_grp2 <= 1'b0;
                            // sort first group [0, fill)
                            r_lo    <= '0;
                            r_hi    <= r_fill;
                            r_i     <= CNT_BITS'(1);
                            r_k     <= CNT_BITS'(1);
                            r_state <= S_SA;
                        end
                    end else begin
                        r_i     <= r_i + 1'b1;
                        r_state <= S_PA;
                    end
                end
                // insertion sort over [lo, hi)
                S_SA: begin
                    if (r_i >= r_hi) begin
                        if (r_lo == '0 && r_hi != r_cnt) begin
                            r_lo <= r_hi; r_hi <= r_cnt;
                            r_i  <= r_hi + 1'b1; r_k <= r_hi + 1'b1;
                        end else begin
                            r_i <= '0;
                            r_state <= S_OA;
                        end
                    end else begin
                        r_key   <= r_ord[r_i[IDX_BITS-1:0]];
                        r_k     <= r_i;
                        r_state <= S_SB;
                    end
                end
                S_SB: begin
                    if (r_k == r_lo) begin
                        r_ord[r_k[IDX_BITS-1:0]] <= r_key;
                        r_i     <= r_i + 1'b1;
                        r_state <= S_SA;
                    end else begin
                        r_state <= S_SM;
                    end
                end
                S_SM: r_state <= S_SC;
                S_SC: begin
                    if (i_stat.precedes) begin
                        r_ord[r_k[IDX_BITS-1:0]] <=
                            r_ord[r_k[IDX_BITS-1:0] - IDX_BITS'(1)];
                        r_k     <= r_k - 1'b1;
                        r_state <= S_SB;
                    end else begin
                        r_ord[r_k[IDX_BITS-1:0]] <= r_key;
                        r_i     <= r_i + 1'b1;
                        r_state <= S_SA;
                    end
                end
                // stream tags out
                S_OA: begin
                    if (r_i == r_cnt) begin
                        r_cnt   <= '0;
                        r_ovf   <= 1'b0;
                        r_state <= S_LOAD;
                    end else begin
                        r_state <= S_OW;
                    end
                end
                S_OW: begin
                    r_out_valid <= 1'b1;
                    r_out_tag   <= i_tag_a;
                    r_out_last  <= (r_i + 1'b1 == r_cnt);
                    r_out_ovf   <= r_ovf;
                    r_state     <= S_OUT;
                end
                S_OUT: begin
                    if (i_out_ready) begin
                        r_out_valid <= 1'b0;
                        r_i         <= r_i + 1'b1;
                        r_state     <= S_OA;
                    end
                end
                default: r_state <= S_LOAD;
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_tag   = r_out_tag;
    assign o_out_last  = r_out_last;
    assign o_out_ovf   = r_out_ovf;

endmodule

`default_nettype wire

### rtl/core/angular_order_sorter_top.sv
// Angular order sorter. Vectors load one per cycle until the item with tlast;
// a full buffer drops further vectors and flags overflow. The set is then
// partitioned in two passes that load, multiply and compare each vector, and
// insertion sorted with a load, multiply and compare per step (shared product
// unit). No new vector is taken until the run is emitted.
`default_nettype none

module angular_order_sorter_top (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [47:0] s_axis_tdata,   // tag[9:0], vec_x[25:10], vec_y[41:26], zero
    input  wire logic        s_axis_tlast,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [15:0]      m_axis_tdata,   // sorted_tag[9:0], zero
    output logic             m_axis_tlast,
    output logic             m_axis_tuser,   // overflow
    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_idx,
    input  wire logic [15:0] i_cfg_data
);
    import aos_pkg::*;

    t_dp_ctrl            w_ctrl;
    t_dp_stat            w_stat;
    logic                w_wr_en;
    logic [IDX_BITS-1:0] w_wr_addr;
    logic [TAG_BITS-1:0] w_tag_a, w_out_tag;

    aos_datapath u_dp (
        .i_clk, .i_rst_n,
        .i_wr_en(w_wr_en), .i_wr_addr(w_wr_addr),
        .i_wr_tag(s_axis_tdata[9:0]),
        .i_wr_x(s_axis_tdata[25:10]), .i_wr_y(s_axis_tdata[41:26]),
        .i_cfg_we, .i_cfg_idx, .i_cfg_data,
        .i_ctrl(w_ctrl), .o_stat(w_stat), .o_tag_a(w_tag_a)
    );

    aos_ctrl u_ctrl (
        .i_clk, .i_rst_n,
        .i_in_valid(s_axis_tvalid), .i_in_last(s_axis_tlast),
        .o_in_ready(s_axis_tready),
        .o_wr_en(w_wr_en), .o_wr_addr(w_wr_addr),
        .o_ctrl(w_ctrl), .i_stat(w_stat), .i_tag_a(w_tag_a),
        .o_out_valid(m_axis_tvalid), .i_out_ready(m_axis_tready),
        .o_out_tag(w_out_tag), .o_out_last(m_axis_tlast), .o_out_ovf(m_axis_tuser)
    );

    assign m_axis_tdata = {6'b0, w_out_tag};

`ifndef SYNTHESIS
    // no input taken while a result is pending
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !s_axis_tready) else $error("input ready during output");
    // a result holds until taken
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output dropped");
`endif

endmodule

`default_nettype wire

### sim/testbench.sv
//------------------------------------------------------------------------------
// testbench
// checks the angular order sorter: loads tagged vector sets over the input
// stream, predicts the sorted tag run and compares every output transaction
//------------------------------------------------------------------------------
`default_nettype none

module testbench;
    import aos_pkg::*;

    // vector set member as seen by the predictor
    typedef struct {
        logic [TAG_BITS-1:0]          tag;
        logic signed [COORD_BITS-1:0] x;
        logic signed [COORD_BITS-1:0] y;
    } t_vec;

    typedef struct {
        logic [TAG_BITS-1:0] tag;
        logic                last;
        logic                ovf;
    } t_tag_out;

    // directed stimulus row; chk_tag < 0 means no typed-in expectation
    typedef struct {
        int  tag;
        int  x;
        int  y;
        bit  last;
        int  chk_tag;
    } t_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata = '0;
    logic        s_axis_tlast = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;
    logic        m_axis_tlast;
    logic        m_axis_tuser;
    logic        i_cfg_we = 1'b0;
    logic        i_cfg_idx = REG_REF_X;
    logic [15:0] i_cfg_data = '0;

    // predictor state
    t_vec                         vec_buf[$];
    bit                           ovf_seen;
    logic signed [COORD_BITS-1:0] dir_x = 1;
    logic signed [COORD_BITS-1:0] dir_y = 0;
    t_tag_out                     tags_due[$];

    int  errors = 0;
    int  hold_off = 0;

    angular_order_sorter_top u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data)
    );

    always #1 i_clk = ~i_clk;

    // sign of the exact cross product a x b
    function automatic int cross_sgn(longint ax, longint ay, longint bx, longint by);
        longint p;
        longint q;
        p = ax * by;
        q = ay * bx;
        return (p > q) ? 1 : ((p < q) ? -1 : 0);
    endfunction

    function automatic bit in_lead_group(t_vec v);
        int c;
        c = cross_sgn(v.x, v.y, dir_x, dir_y);
        return (c < 0) || (c == 0 && (longint'(v.x) * dir_x + longint'(v.y) * dir_y > 0));
    endfunction

    // stable insertion sort by angle within one group
    function automatic void angle_sort(ref t_vec grp[$]);
        t_vec key;
        int   k;
        for (int i = 1; i < grp.size(); i++) begin
            key = grp[i];
            k = i;
            while (k > 0 && cross_sgn(key.x, key.y, grp[k-1].x, grp[k-1].y) > 0) begin
                grp[k] = grp[k-1];
                k--;
            end
            grp[k] = key;
        end
    endfunction

    // absorb one accepted vector and queue the sorted run on last
    function automatic void absorb_vector(t_vec v, bit last);
        t_vec     lead[$];
        t_vec     trail[$];
        t_tag_out o;
        if (vec_buf.size() < MAX_POINTS) vec_buf.push_back(v);
        else ovf_seen = 1'b1;
        if (!last) return;
        foreach (vec_buf[i]) begin
            if (in_lead_group(vec_buf[i])) lead.push_back(vec_buf[i]);
            else trail.push_back(vec_buf[i]);
        end
        angle_sort(lead);
        angle_sort(trail);
        lead = {lead, trail};
        foreach (lead[i]) begin
            o.tag  = lead[i].tag;
            o.last = (i == lead.size() - 1);
            o.ovf  = ovf_seen;
            tags_due.push_back(o);
        end
        vec_buf.delete();
        ovf_seen = 1'b0;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
        errors++;
    endtask

    // output checker
    always @(posedge i_clk) begin
        t_tag_out w;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (tags_due.size() == 0) begin
                report_mismatch("unexpected tag", m_axis_tdata[9:0], -1);
            end else begin
                w = tags_due.pop_front();
                if (m_axis_tdata[9:0] !== w.tag) report_mismatch("tag", m_axis_tdata[9:0], w.tag);
                if (m_axis_tlast !== w.last) report_mismatch("last", m_axis_tlast, w.last);
                if (m_axis_tuser !== w.ovf) report_mismatch("overflow", m_axis_tuser, w.ovf);
            end
        end
    end

    // receiver stall pattern plus long hold-off stretches
    always @(posedge i_clk) begin
        if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            m_axis_tready <= 1'b0;
        end else begin
            case ($urandom_range(0, 3))
                0: m_axis_tready <= ($urandom_range(0, 3) == 0);
                default: m_axis_tready <= 1'b1;
            endcase
        end
    end

    task automatic write_reg(logic idx, logic [15:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == REG_REF_X) dir_x = val;
        else dir_y = val;
        @(posedge i_clk);
    endtask

    // wait for the block to drain, then a margin for safety
    task automatic drain();
        while (tags_due.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    // offer one vector and wait for the transaction
    task automatic send_vector(t_vec v, bit last, bit gap_ok);
        if (gap_ok && $urandom_range(0, 4) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {6'b0, v.y, v.x, v.tag};
        s_axis_tlast  <= last;
        do @(posedge i_clk); while (!s_axis_tready);
        absorb_vector(v, last);
    endtask

    function automatic logic signed [15:0] rand_coord();
        case ($urandom_range(0, 5))
            0: return 16'sh8000;
            1: return 16'sh7fff;
            2: return '0;
            3: return 16'($urandom_range(0, 6) - 3);
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic random_set(int n, bit gaps);
        t_vec v;
        for (int i = 0; i < n; i++) begin
            v.tag = TAG_BITS'($urandom);
            v.x   = rand_coord();
            v.y   = rand_coord();
            send_vector(v, i == n - 1, gaps);
        end
        s_axis_tvalid <= 1'b0;
    endtask

    t_row rows[] = '{
        '{0,    5,      0,      1'b1, 0},      // single vector along reference
        '{1,    0,      0,      1'b1, 1},      // zero vector alone
        '{1023, 32767,  32767,  1'b0, -1},
        '{2,    -32768, -32768, 1'b0, -1},
        '{3,    -32768, 32767,  1'b0, -1},
        '{4,    32767,  -32768, 1'b0, -1},
        '{5,    0,      0,      1'b0, -1},
        '{6,    -1,     0,      1'b0, -1},     // opposite reference
        '{7,    3,      0,      1'b0, -1},     // tie with next on the reference ray
        '{8,    9,      0,      1'b0, -1},
        '{9,    0,      -7,     1'b0, -1},
        '{10,   0,      7,      1'b1, -1}
    };

    int n_items;
    t_vec v;

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed rows at reset reference
        foreach (rows[i]) begin
            v.tag = TAG_BITS'(rows[i].tag);
            v.x   = COORD_BITS'(rows[i].x);
            v.y   = COORD_BITS'(rows[i].y);
            if (rows[i].chk_tag >= 0) begin
                // typed-in expectation cross-checks the predictor
                send_vector(v, rows[i].last, 1'b0);
                if (tags_due.size() == 0 || tags_due[$].tag != rows[i].chk_tag)
                    report_mismatch("directed prediction", -1, rows[i].chk_tag);
            end else begin
                send_vector(v, rows[i].last, 1'b0);
            end
        end
        s_axis_tvalid <= 1'b0;
        drain();

        // full buffer, overflow on the last three vectors, with a long receiver hold-off
        hold_off = 400;
        random_set(MAX_POINTS + 3, 1'b0);
        drain();
        random_set(MAX_POINTS, 1'b0);
        drain();

        // zero reference then the extremes
        write_reg(REG_REF_X, 16'h0000);
        write_reg(REG_REF_Y, 16'h0000);
        random_set(6, 1'b1);
        drain();
        write_reg(REG_REF_X, 16'h8000);
        write_reg(REG_REF_Y, 16'h7fff);
        random_set(8, 1'b1);
        drain();
        write_reg(REG_REF_X, 16'h7fff);
        write_reg(REG_REF_Y, 16'h8000);
        random_set(8, 1'b1);
        drain();

        // random sets under random references
        n_items = 0;
        while (n_items < 330) begin
            int n;
            if ($urandom_range(0, 2) == 0) begin
                write_reg(REG_REF_X, rand_coord());
                write_reg(REG_REF_Y, rand_coord());
            end
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 36) : $urandom_range(1, 8);
            if ($urandom_range(0, 7) == 0) hold_off = $urandom_range(50, 200);
            random_set(n, $urandom_range(0, 3) != 0);
            n_items += n;
            drain();
        end

        drain();
        if (errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    // run limit
    initial begin
        #4000000;
        $display("Some tests failed");
        $finish;
    end

endmodule

`default_nettype wire

### files.f
rtl/core/aos_pkg.sv
rtl/core/aos_datapath.sv
rtl/core/aos_ctrl.sv
rtl/core/angular_order_sorter_top.sv
sim/testbench.sv
